// ----- rtl/plt_pkg.sv -----
`timescale 1ns / 1ps
package plt_pkg;

    typedef logic [7:0] byte_t;

    // Character codes the tokenizer reacts to, and the case-fold offset.
    localparam byte_t CH_HASH  = 8'h23;
    localparam byte_t CH_SEMI  = 8'h3B;
    localparam byte_t CH_DQ    = 8'h22;
    localparam byte_t CH_EQ    = 8'h3D;
    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_STAR  = 8'h2A;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_UPA   = 8'h41;
    localparam byte_t CH_UPZ   = 8'h5A;
    localparam byte_t CASE_OFS = 8'h20;

    // Lexer modes.
    localparam logic [2:0] MODE_SKIP   = 3'd0;
    localparam logic [2:0] MODE_NORMAL = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_QESC   = 3'd3;
    localparam logic [2:0] MODE_LINE   = 3'd4;
    localparam logic [2:0] MODE_BLOCK  = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_RAW   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Chunk geometry.
    localparam int         CHUNK_BYTES = 8;
    localparam logic [3:0] COUNT_FULL  = 4'd8;

endpackage

// ----- rtl/plt_ram.sv -----
`timescale 1ns / 1ps
module plt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/property_line_tokenizer_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_        in         tdata[7:0] data_byte
// m_        out        tdata[63:0] chunk_bytes, [67:64] byte_count; tuser kind; tlast last
// cfg_      in         cfg_wdata case_fold, written when cfg_wen is high
//
// A byte that ends no token is lexed, then its stored characters (0 to 3) are written to
// the token store one by one. A token end adds a quote check of the value, an escape check
// of each byte of a quoted value, and a chunk-by-chunk walk of the token store through its
// single read port; one shared sequencer does all of this.
// Reset is synchronous, active low, and clears all control state; the store is not cleared.
// s_tready is low while a byte or a token is being worked on; a stalled m_ side holds the walk.
module property_line_tokenizer_core #(
    parameter int TOKEN_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] chunk_bytes, [67:64] byte_count, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last
    input  logic        cfg_wen,
    input  logic        cfg_wdata  // [0] case_fold
);
    import plt_pkg::*;

    localparam int AW = $clog2(TOKEN_BYTES);
    localparam int LW = $clog2(TOKEN_BYTES + 1);
    localparam logic [LW-1:0] TB_L = LW'(TOKEN_BYTES);
    localparam logic [LW-1:0] ONE_L = LW'(1);
    localparam logic [LW-1:0] TWO_L = LW'(2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PUSH = 4'd1;
    localparam logic [3:0] S_END  = 4'd2;
    localparam logic [3:0] S_CK1  = 4'd3;
    localparam logic [3:0] S_CK2  = 4'd4;
    localparam logic [3:0] S_CK3  = 4'd5;
    localparam logic [3:0] S_CK4  = 4'd6;
    localparam logic [3:0] S_SCR  = 4'd7;
    localparam logic [3:0] S_SCD  = 4'd8;
    localparam logic [3:0] S_RD   = 4'd9;
    localparam logic [3:0] S_DAT  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    mode_reg, mode_next;
    logic [1:0]    hc_reg, hc_next;
    byte_t         h0_reg, h0_next, h1_reg, h1_next;
    logic [LW-1:0] raw_reg, raw_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] eqpos_reg, eqpos_next;
    logic          eqseen_reg, eqseen_next;
    logic [1:0]    qp_reg, qp_next;
    logic          fold_reg;
    byte_t         q_reg [0:4];
    byte_t         q_next [0:4];
    logic [2:0]    qn_reg, qn_next, qi_reg, qi_next;
    logic          endf_reg, endf_next;
    logic [LW-1:0] ptr_reg, ptr_next, end_reg, end_next;
    logic          quoted_reg, quoted_next, firstq_reg, firstq_next;
    logic [1:0]    kind_reg, kind_next;
    logic          seglast_reg, seglast_next, unesc_reg, unesc_next;
    logic          esc_reg, esc_next, any_reg, any_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [63:0]   acc_reg, acc_next;
    logic          mvalid_reg, mvalid_next;
    logic [63:0]   mchunk_reg, mchunk_next;
    logic [3:0]    mcount_reg, mcount_next;
    logic [1:0]    mkind_reg, mkind_next;
    logic          mlast_reg, mlast_next;

    byte_t         ram_rdata;
    logic          ram_we;

    // Lexer decisions for one accepted byte.
    byte_t         lx_q [0:4];
    logic [2:0]    lx_qn;
    logic [2:0]    lx_mode;
    logic [1:0]    lx_hc;
    byte_t         lx_h0, lx_h1;
    logic          lx_end;
    logic [LW-1:0] lx_raw;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0000, mcount_reg, mchunk_reg};
    assign m_tuser  = mkind_reg;
    assign m_tlast  = mlast_reg;

    plt_ram #(.WIDTH(8), .DEPTH(TOKEN_BYTES)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (q_reg[qi_reg]),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_we = (state_reg == S_PUSH) && (len_reg < TB_L);

    // Byte lexer: characters to store, end of token, next mode and lookahead.
    always_comb begin
        logic  nfresh;
        logic  qfresh;
        byte_t b;
        b      = s_tdata;
        nfresh = 1'b0;
        qfresh = 1'b0;
        for (int i = 0; i < 5; i++) begin
            lx_q[i] = 8'h00;
        end
        lx_qn   = 3'd0;
        lx_mode = mode_reg;
        lx_hc   = hc_reg;
        lx_h0   = h0_reg;
        lx_h1   = h1_reg;
        lx_end  = 1'b0;
        lx_raw  = raw_reg;
        if (mode_reg == MODE_SKIP && (b == CH_LF || b == CH_CR || b == CH_SEMI)) begin
            lx_mode = MODE_SKIP;
        end else begin
            if (mode_reg == MODE_SKIP || mode_reg > MODE_BLOCK) begin
                lx_mode = MODE_NORMAL;
            end
            lx_raw = raw_reg + ONE_L;
            unique case (lx_mode)
                MODE_QUOTED, MODE_QESC: begin
                    qfresh = 1'b1;
                    if (hc_reg != 2'd0) begin
                        lx_hc = 2'd0;
                        if (b == CH_LF) begin
                            lx_end = 1'b1;
                            qfresh = 1'b0;
                        end else begin
                            lx_q[lx_qn] = CH_CR;
                            lx_qn = lx_qn + 3'd1;
                            lx_mode = MODE_QUOTED;
                        end
                    end
                end
                MODE_LINE: begin
                    if (b == CH_LF) begin
                        lx_end = 1'b1;
                    end
                end
                MODE_BLOCK: begin
                    if (hc_reg != 2'd0 && b == CH_SLASH) begin
                        lx_hc = 2'd0;
                        lx_mode = MODE_NORMAL;
                    end else if (b == CH_STAR) begin
                        lx_hc = 2'd1;
                        lx_h0 = b;
                    end else begin
                        lx_hc = 2'd0;
                    end
                end
                default: begin
                    if (hc_reg == 2'd0) begin
                        nfresh = 1'b1;
                    end else if (hc_reg == 2'd2) begin
                        lx_hc = 2'd0;
                        if (b != CH_LF) begin
                            lx_q[0] = CH_BSL;
                            lx_q[1] = CH_CR;
                            lx_qn = 3'd2;
                            nfresh = 1'b1;
                        end
                    end else begin
                        lx_hc = 2'd0;
                        if (h0_reg == CH_CR) begin
                            if (b == CH_LF) begin
                                lx_end = 1'b1;
                            end else begin
                                lx_q[0] = CH_CR;
                                lx_qn = 3'd1;
                                nfresh = 1'b1;
                            end
                        end else if (h0_reg == CH_SLASH) begin
                            if (b == CH_STAR) begin
                                lx_mode = MODE_BLOCK;
                            end else begin
                                lx_q[0] = CH_SLASH;
                                lx_qn = 3'd1;
                                nfresh = 1'b1;
                            end
                        end else begin
                            if (b == CH_CR) begin
                                lx_hc = 2'd2;
                                lx_h0 = CH_BSL;
                                lx_h1 = CH_CR;
                            end else if (b != CH_LF) begin
                                lx_q[0] = CH_BSL;
                                lx_qn = 3'd1;
                                nfresh = 1'b1;
                            end
                        end
                    end
                end
            endcase

            // A fresh byte outside quotes.
            if (nfresh) begin
                if (b == CH_HASH) begin
                    lx_mode = MODE_LINE;
                end else if (b == CH_SLASH || b == CH_BSL || b == CH_CR) begin
                    lx_hc = 2'd1;
                    lx_h0 = b;
                end else if (b == CH_SEMI || b == CH_LF) begin
                    lx_end = 1'b1;
                end else if (b != CH_SPACE && b != CH_TAB) begin
                    lx_q[lx_qn] = b;
                    lx_qn = lx_qn + 3'd1;
                    if (b == CH_DQ) begin
                        lx_mode = MODE_QUOTED;
                    end
                end
            end

            // A fresh byte inside quotes.
            if (qfresh) begin
                if (b == CH_LF) begin
                    lx_end = 1'b1;
                end else if (b == CH_CR) begin
                    lx_hc = 2'd1;
                    lx_h0 = b;
                end else if (lx_mode == MODE_QESC) begin
                    lx_q[lx_qn] = b;
                    lx_qn = lx_qn + 3'd1;
                    lx_mode = MODE_QUOTED;
                end else begin
                    lx_q[lx_qn] = b;
                    lx_qn = lx_qn + 3'd1;
                    if (b == CH_BSL) begin
                        lx_mode = MODE_QESC;
                    end else if (b == CH_DQ) begin
                        lx_mode = MODE_NORMAL;
                    end
                end
            end

            // Store full: held lookahead becomes text, then the token ends.
            if (!lx_end && lx_raw == TB_L) begin
                if (lx_mode == MODE_NORMAL) begin
                    if (lx_hc != 2'd0) begin
                        lx_q[lx_qn] = lx_h0;
                        lx_qn = lx_qn + 3'd1;
                    end
                    if (lx_hc == 2'd2) begin
                        lx_q[lx_qn] = lx_h1;
                        lx_qn = lx_qn + 3'd1;
                    end
                end else if (lx_mode == MODE_QUOTED || lx_mode == MODE_QESC) begin
                    if (lx_hc != 2'd0) begin
                        lx_q[lx_qn] = lx_h0;
                        lx_qn = lx_qn + 3'd1;
                    end
                end
                lx_end = 1'b1;
            end
        end
        if (lx_end) begin
            lx_mode = MODE_SKIP;
            lx_hc   = 2'd0;
            lx_raw  = '0;
        end
    end

    // Sequencer: store characters, check the token, walk the store into chunks.
    always_comb begin
        byte_t         c;
        byte_t         cv;
        logic          app;
        logic [LW-1:0] pn;
        logic [LW-1:0] v0;
        logic [LW-1:0] vlen;
        logic          go_mal;
        logic          go_name;
        logic          go_value;
        logic          tok_clear;

        state_next   = state_reg;
        mode_next    = mode_reg;
        hc_next      = hc_reg;
        h0_next      = h0_reg;
        h1_next      = h1_reg;
        raw_next     = raw_reg;
        len_next     = len_reg;
        eqpos_next   = eqpos_reg;
        eqseen_next  = eqseen_reg;
        qp_next      = qp_reg;
        for (int i = 0; i < 5; i++) begin
            q_next[i] = q_reg[i];
        end
        qn_next      = qn_reg;
        qi_next      = qi_reg;
        endf_next    = endf_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        quoted_next  = quoted_reg;
        firstq_next  = firstq_reg;
        kind_next    = kind_reg;
        seglast_next = seglast_reg;
        unesc_next   = unesc_reg;
        esc_next     = esc_reg;
        any_next     = any_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mchunk_next  = mchunk_reg;
        mcount_next  = mcount_reg;
        mkind_next   = mkind_reg;
        mlast_next   = mlast_reg;

        c         = ram_rdata;
        cv        = ram_rdata;
        app       = 1'b1;
        pn        = ptr_reg + ONE_L;
        v0        = eqpos_reg + ONE_L;
        vlen      = len_reg - v0;
        go_mal    = 1'b0;
        go_name   = 1'b0;
        go_value  = 1'b0;
        tok_clear = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = lx_mode;
                    hc_next   = lx_hc;
                    h0_next   = lx_h0;
                    h1_next   = lx_h1;
                    raw_next  = lx_raw;
                    for (int i = 0; i < 5; i++) begin
                        q_next[i] = lx_q[i];
                    end
                    qn_next   = lx_qn;
                    qi_next   = 3'd0;
                    endf_next = lx_end;
                    if (lx_qn != 3'd0) begin
                        state_next = S_PUSH;
                    end else if (lx_end) begin
                        state_next = S_END;
                    end
                end
            end
            S_PUSH: begin
                // One character per cycle through the store's write port.
                if (len_reg < TB_L) begin
                    if (q_reg[qi_reg] == CH_EQ && !eqseen_reg) begin
                        eqseen_next = 1'b1;
                        eqpos_next  = len_reg;
                    end
                    if (qp_reg[1]) begin
                        qp_next = {1'b0, qp_reg[0]};
                    end else if (q_reg[qi_reg] == CH_BSL) begin
                        qp_next = {1'b1, qp_reg[0]};
                    end else if (q_reg[qi_reg] == CH_DQ) begin
                        qp_next = {qp_reg[1], !qp_reg[0]};
                    end
                    len_next = len_reg + ONE_L;
                end
                qi_next = qi_reg + 3'd1;
                if (qi_reg + 3'd1 == qn_reg) begin
                    state_next = endf_reg ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (len_reg == '0) begin
                    tok_clear = 1'b1;
                end else if (qp_reg[0] || !eqseen_reg || eqpos_reg == '0) begin
                    go_mal = 1'b1;
                end else if (vlen < TWO_L) begin
                    quoted_next = 1'b0;
                    go_name     = 1'b1;
                end else begin
                    ptr_next   = v0;
                    state_next = S_CK1;
                end
            end
            S_CK1: begin
                state_next = S_CK2;
            end
            S_CK2: begin
                firstq_next = (c == CH_DQ);
                ptr_next    = len_reg - ONE_L;
                state_next  = S_CK3;
            end
            S_CK3: begin
                state_next = S_CK4;
            end
            S_CK4: begin
                quoted_next = firstq_reg && (c == CH_DQ);
                esc_next    = 1'b0;
                if (!(firstq_reg && (c == CH_DQ)) || vlen == TWO_L) begin
                    go_name = 1'b1;
                end else begin
                    ptr_next   = v0 + ONE_L;
                    state_next = S_SCR;
                end
            end
            S_SCR: begin
                state_next = S_SCD;
            end
            S_SCD: begin
                // Look for a backslash left open before the closing quote.
                if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (c == CH_BSL) begin
                    esc_next = 1'b1;
                end
                ptr_next = pn;
                if (pn == len_reg - ONE_L) begin
                    if (esc_reg || c != CH_BSL) begin
                        go_name = 1'b1;
                    end else begin
                        go_mal = 1'b1;
                    end
                end else begin
                    state_next = S_SCR;
                end
            end
            S_RD: begin
                if (ptr_reg == end_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_DAT;
                end
            end
            S_DAT: begin
                if (unesc_reg) begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (c == CH_BSL) begin
                        esc_next = 1'b1;
                        app      = 1'b0;
                    end
                end else if (kind_reg != KIND_VALUE && fold_reg &&
                             c >= CH_UPA && c <= CH_UPZ) begin
                    cv = c + CASE_OFS;
                end
                if (app) begin
                    acc_next[{cnt_reg[2:0], 3'b000} +: 8] = cv;
                    cnt_next = cnt_reg + 4'd1;
                end
                ptr_next = pn;
                if (cnt_next == COUNT_FULL ||
                    (pn == end_reg && (cnt_next != 4'd0 || !any_reg))) begin
                    state_next = S_OUT;
                end else if (pn == end_reg) begin
                    if (kind_reg == KIND_NAME) begin
                        go_value = 1'b1;
                    end else begin
                        tok_clear = 1'b1;
                    end
                end else begin
                    state_next = S_RD;
                end
            end
            S_OUT: begin
                // Hand a chunk to the output register once it is free.
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mchunk_next = acc_reg;
                    mcount_next = cnt_reg;
                    mkind_next  = kind_reg;
                    mlast_next  = seglast_reg && (ptr_reg == end_reg);
                    any_next    = 1'b1;
                    cnt_next    = 4'd0;
                    acc_next    = '0;
                    if (ptr_reg != end_reg) begin
                        state_next = S_RD;
                    end else if (kind_reg == KIND_NAME) begin
                        go_value = 1'b1;
                    end else begin
                        tok_clear = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Segment setup for the store walk.
        if (go_mal || go_name || go_value) begin
            esc_next   = 1'b0;
            any_next   = 1'b0;
            cnt_next   = 4'd0;
            acc_next   = '0;
            state_next = S_RD;
        end
        if (go_mal) begin
            kind_next    = KIND_RAW;
            ptr_next     = '0;
            end_next     = len_reg;
            unesc_next   = 1'b0;
            seglast_next = 1'b1;
        end
        if (go_name) begin
            kind_next    = KIND_NAME;
            ptr_next     = '0;
            end_next     = eqpos_reg;
            unesc_next   = 1'b0;
            seglast_next = 1'b0;
        end
        if (go_value) begin
            kind_next    = KIND_VALUE;
            ptr_next     = quoted_reg ? v0 + ONE_L : v0;
            end_next     = quoted_reg ? len_reg - ONE_L : len_reg;
            unesc_next   = quoted_reg;
            seglast_next = 1'b1;
        end
        if (tok_clear) begin
            len_next    = '0;
            eqpos_next  = '0;
            eqseen_next = 1'b0;
            qp_next     = 2'd0;
            state_next  = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_SKIP;
            hc_reg     <= 2'd0;
            raw_reg    <= '0;
            len_reg    <= '0;
            eqpos_reg  <= '0;
            eqseen_reg <= 1'b0;
            qp_reg     <= 2'd0;
            fold_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            hc_reg     <= hc_next;
            raw_reg    <= raw_next;
            len_reg    <= len_next;
            eqpos_reg  <= eqpos_next;
            eqseen_reg <= eqseen_next;
            qp_reg     <= qp_next;
            mvalid_reg <= mvalid_next;
            if (cfg_wen) begin
                fold_reg <= cfg_wdata;
            end
        end
    end

    // Payload and walk registers.
    always_ff @(posedge aclk) begin
        h0_reg      <= h0_next;
        h1_reg      <= h1_next;
        for (int i = 0; i < 5; i++) begin
            q_reg[i] <= q_next[i];
        end
        qn_reg      <= qn_next;
        qi_reg      <= qi_next;
        endf_reg    <= endf_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        quoted_reg  <= quoted_next;
        firstq_reg  <= firstq_next;
        kind_reg    <= kind_next;
        seglast_reg <= seglast_next;
        unesc_reg   <= unesc_next;
        esc_reg     <= esc_next;
        any_reg     <= any_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        mchunk_reg  <= mchunk_next;
        mcount_reg  <= mcount_next;
        mkind_reg   <= mkind_next;
        mlast_reg   <= mlast_next;
    end

endmodule

// ----- rtl/plt_checker.sv -----
`timescale 1ns / 1ps
module plt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import plt_pkg::*;

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Chunk counts never exceed one chunk.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:64] <= COUNT_FULL)
        else $error("byte count above eight");

    // Only the three defined kinds appear.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != KIND_NONE)
        else $error("undefined kind");

    // An empty chunk is only the final chunk of an empty value.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[67:64] == 4'd0 |-> m_tuser == KIND_VALUE && m_tlast)
        else $error("empty chunk outside an empty value");

endmodule

bind property_line_tokenizer_core plt_checker u_plt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import plt_pkg::*;

    localparam int TOK_BYTES   = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 1500;
    localparam int PHASE_ITEMS = 40;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } chunk_t;

    typedef struct {
        byte_t       b;
        bit          chk;
        logic [1:0]  kind;
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
    } drow_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;

    property_line_tokenizer_core #(.TOKEN_BYTES(TOK_BYTES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    // Clock generation.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    chunk_t expected_chunks[$];
    byte_t  stim[$];
    int     errors = 0;
    int     cycles = 0;
    int     items_sent = 0;
    int     chunks_seen = 0;
    int     long_tokens = 0;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     stall_left = 0;
    bit     steady = 1'b0;

    // Tokenizer state mirrored by the predictor.
    logic [2:0] lx_mode = MODE_SKIP;
    byte_t      held_lo, held_hi;
    int         held_n, raw_n, tok_len, eq_pos;
    bit         eq_seen, fold_on;
    logic [1:0] qpar;
    byte_t      tok_store[TOK_BYTES];

    function automatic byte_t lower(byte_t c);
        if (fold_on && c >= CH_UPA && c <= CH_UPZ)
            return c + CASE_OFS;
        return c;
    endfunction

    task automatic add_byte(byte_t b);
        stim.insert(stim.size(), b);
    endtask

    task automatic store_char(byte_t c);
        if (tok_len >= TOK_BYTES)
            return;
        tok_store[tok_len] = c;
        if (c == CH_EQ && !eq_seen) begin
            eq_seen = 1'b1;
            eq_pos = tok_len;
        end
        if (qpar[1])
            qpar[1] = 1'b0;
        else if (c == CH_BSL)
            qpar[1] = 1'b1;
        else if (c == CH_DQ)
            qpar[0] = ~qpar[0];
        tok_len++;
    endtask

    task automatic put_chunks(logic [1:0] kind, byte_t src[TOK_BYTES], int len, bit fin);
        int     i;
        int     k;
        chunk_t ch;
        i = 0;
        do begin
            k = (len - i > CHUNK_BYTES) ? CHUNK_BYTES : len - i;
            ch.kind = kind;
            ch.data = '0;
            for (int j = 0; j < k; j++)
                ch.data[8*j +: 8] = src[i + j];
            ch.cnt = 4'(k);
            ch.last = fin && (i + k >= len);
            expected_chunks.insert(expected_chunks.size(), ch);
            i += k;
        end while (i < len);
    endtask

    task automatic emit_raw();
        byte_t folded[TOK_BYTES];
        for (int i = 0; i < tok_len; i++)
            folded[i] = lower(tok_store[i]);
        put_chunks(KIND_RAW, folded, tok_len, 1'b1);
    endtask

    // Splits a finished token into name and value chunks, or raw chunks if malformed.
    task automatic emit_token();
        byte_t name[TOK_BYTES];
        byte_t val[TOK_BYTES];
        int    n;
        int    v0;
        int    vlen;
        bit    esc;
        n = tok_len;
        if (n == 0)
            return;
        if (qpar[0] || !eq_seen || eq_pos == 0 || eq_pos >= n) begin
            emit_raw();
            return;
        end
        v0 = eq_pos + 1;
        vlen = 0;
        if (n - v0 >= 2 && tok_store[v0] == CH_DQ && tok_store[n-1] == CH_DQ) begin
            esc = 1'b0;
            for (int i = v0 + 1; i + 1 < n; i++) begin
                if (esc) begin
                    val[vlen++] = tok_store[i];
                    esc = 1'b0;
                end else if (tok_store[i] == CH_BSL) begin
                    esc = 1'b1;
                end else begin
                    val[vlen++] = tok_store[i];
                end
            end
            if (esc) begin
                emit_raw();
                return;
            end
        end else begin
            for (int i = v0; i < n; i++)
                val[vlen++] = tok_store[i];
        end
        for (int i = 0; i < eq_pos; i++)
            name[i] = lower(tok_store[i]);
        put_chunks(KIND_NAME, name, eq_pos, 1'b0);
        put_chunks(KIND_VALUE, val, vlen, 1'b1);
    endtask

    task automatic finish_token();
        emit_token();
        tok_len = 0;
        eq_pos = 0;
        eq_seen = 1'b0;
        qpar = '0;
        held_lo = '0;
        held_hi = '0;
        held_n = 0;
        raw_n = 0;
        lx_mode = MODE_SKIP;
    endtask

    task automatic hold_one(byte_t b);
        held_lo = b;
        held_n = 1;
    endtask

    task automatic clear_held();
        held_lo = '0;
        held_hi = '0;
        held_n = 0;
    endtask

    task automatic normal_fresh(byte_t b);
        if (b == CH_HASH)
            lx_mode = MODE_LINE;
        else if (b == CH_SLASH || b == CH_BSL || b == CH_CR)
            hold_one(b);
        else if (b == CH_SPACE || b == CH_TAB)
            ;
        else if (b == CH_SEMI || b == CH_LF)
            finish_token();
        else begin
            store_char(b);
            if (b == CH_DQ)
                lx_mode = MODE_QUOTED;
        end
    endtask

    task automatic quoted_fresh(byte_t b);
        if (b == CH_LF) begin
            finish_token();
        end else if (b == CH_CR) begin
            hold_one(b);
        end else if (lx_mode == MODE_QESC) begin
            store_char(b);
            lx_mode = MODE_QUOTED;
        end else begin
            store_char(b);
            if (b == CH_BSL)
                lx_mode = MODE_QESC;
            else if (b == CH_DQ)
                lx_mode = MODE_NORMAL;
        end
    endtask

    // Resolves a held lookahead byte against the new one outside quotes.
    task automatic normal_byte(byte_t b);
        byte_t h;
        h = held_lo;
        if (held_n == 0) begin
            normal_fresh(b);
            return;
        end
        if (held_n >= 2) begin
            clear_held();
            if (b == CH_LF)
                return;
            store_char(CH_BSL);
            store_char(CH_CR);
            normal_fresh(b);
            return;
        end
        clear_held();
        if (h == CH_CR) begin
            if (b == CH_LF) begin
                finish_token();
                return;
            end
            store_char(CH_CR);
        end else if (h == CH_SLASH) begin
            if (b == CH_STAR) begin
                lx_mode = MODE_BLOCK;
                return;
            end
            store_char(CH_SLASH);
        end else begin
            if (b == CH_LF)
                return;
            if (b == CH_CR) begin
                held_lo = CH_BSL;
                held_hi = CH_CR;
                held_n = 2;
                return;
            end
            store_char(CH_BSL);
        end
        normal_fresh(b);
    endtask

    task automatic flush_held();
        if (lx_mode == MODE_NORMAL) begin
            if (held_n >= 1)
                store_char(held_lo);
            if (held_n >= 2)
                store_char(held_hi);
        end else if (lx_mode == MODE_QUOTED || lx_mode == MODE_QESC) begin
            if (held_n >= 1)
                store_char(held_lo);
        end
        clear_held();
    endtask

    // Advances the predictor by one byte and appends the chunks it yields.
    task automatic predict_byte(byte_t b);
        bit done;
        done = 1'b0;
        if (lx_mode == MODE_SKIP) begin
            if (b == CH_LF || b == CH_CR || b == CH_SEMI)
                return;
            lx_mode = MODE_NORMAL;
        end
        raw_n++;
        case (lx_mode)
            MODE_NORMAL: begin
                normal_byte(b);
            end
            MODE_QUOTED, MODE_QESC: begin
                if (held_n != 0) begin
                    clear_held();
                    if (b == CH_LF) begin
                        finish_token();
                        done = 1'b1;
                    end else begin
                        store_char(CH_CR);
                        lx_mode = MODE_QUOTED;
                    end
                end
                if (!done)
                    quoted_fresh(b);
            end
            MODE_LINE: begin
                if (b == CH_LF)
                    finish_token();
            end
            MODE_BLOCK: begin
                if (held_n != 0) begin
                    clear_held();
                    if (b == CH_SLASH) begin
                        lx_mode = MODE_NORMAL;
                        done = 1'b1;
                    end
                end
                if (!done && b == CH_STAR)
                    hold_one(b);
            end
            default: begin
                lx_mode = MODE_NORMAL;
                normal_byte(b);
            end
        endcase
        if (lx_mode != MODE_SKIP && raw_n >= TOK_BYTES) begin
            flush_held();
            finish_token();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one byte, waits for its transaction, then predicts it.
    task automatic send_byte(byte_t b, output int first, output int nres);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        first = expected_chunks.size();
        predict_byte(b);
        nres = expected_chunks.size() - first;
        items_sent++;
    endtask

    task automatic write_fold(bit v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        fold_on = v;
    endtask

    // Waits until every expected chunk has arrived and the block has settled.
    task automatic drain();
        while (expected_chunks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Random stimulus generation.
    function automatic byte_t plain_char();
        byte_t c;
        do c = byte_t'($urandom_range(33, 126));
        while (c == CH_SEMI || c == CH_DQ || c == CH_BSL || c == CH_HASH ||
               c == CH_SLASH || c == CH_EQ);
        return c;
    endfunction

    function automatic byte_t name_char();
        if ($urandom_range(0, 1))
            return CH_UPA + byte_t'($urandom_range(0, 25));
        return 8'h61 + byte_t'($urandom_range(0, 25));
    endfunction

    task automatic add_terminator();
        case ($urandom_range(0, 2))
            0: add_byte(CH_SEMI);
            1: add_byte(CH_LF);
            default: begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endtask

    task automatic gen_phase(int target, bit with_long);
        int    r;
        int    base;
        byte_t specials[9];
        specials = '{CH_CR, CH_BSL, CH_SLASH, CH_STAR, CH_DQ, CH_EQ, CH_SEMI, CH_LF, CH_TAB};
        if (with_long) begin
            // Long property that forces a token at the store size.
            long_tokens++;
            add_byte(name_char());
            add_byte(CH_EQ);
            repeat (TOK_BYTES + 20) add_byte(plain_char());
            add_byte(CH_LF);
        end
        base = stim.size();
        while (stim.size() < base + target) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                // Well-formed property with random content.
                if ($urandom_range(0, 3) == 0)
                    add_byte(CH_SPACE);
                repeat ($urandom_range(1, 6)) add_byte(name_char());
                if ($urandom_range(0, 4) == 0)
                    add_byte(CH_TAB);
                add_byte(CH_EQ);
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(0, 10)) add_byte(plain_char());
                    if ($urandom_range(0, 5) == 0) begin
                        add_byte(CH_BSL);
                        add_byte(CH_LF);
                        add_byte(plain_char());
                    end
                end else begin
                    add_byte(CH_DQ);
                    repeat ($urandom_range(0, 8)) begin
                        if ($urandom_range(0, 4) == 0)
                            add_byte(CH_BSL);
                        add_byte($urandom_range(0, 2) ? plain_char() : CH_SPACE);
                    end
                    add_byte(CH_DQ);
                end
                add_terminator();
            end else if (r < 65) begin
                // Line or block comment.
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_HASH);
                    repeat ($urandom_range(0, 5)) add_byte(plain_char());
                    add_byte(CH_LF);
                end else begin
                    add_byte(CH_SLASH);
                    add_byte(CH_STAR);
                    repeat ($urandom_range(0, 5))
                        add_byte($urandom_range(0, 1) ? plain_char() : CH_LF);
                    add_byte(CH_STAR);
                    add_byte(CH_SLASH);
                end
            end else if (r < 80) begin
                repeat ($urandom_range(1, 6)) add_byte(byte_t'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 5)) add_byte(specials[$urandom_range(0, 8)]);
            end
        end
    endtask

    task automatic run_random(int target, bit with_long);
        int first;
        int nres;
        stim.delete();
        gen_phase(target, with_long);
        foreach (stim[i])
            send_byte(stim[i], first, nres);
        s_tvalid <= 1'b0;
        drain();
    endtask

    // Receiver readiness with random stalls and one long hold-off on request.
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            stall_left <= 400;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (steady || r < 70) begin
            m_tready <= 1'b1;
        end else if (r < 95) begin
            stall_left <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            stall_left <= $urandom_range(10, 40);
            m_tready <= 1'b0;
        end
    end

    function automatic void check_field(string f, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, f, e, a);
            errors++;
        end
    endfunction

    // Result checker: each transaction against the oldest expectation.
    always @(posedge aclk) begin
        chunk_t e;
        if (aresetn && m_tvalid && m_tready) begin
            chunks_seen++;
            if (expected_chunks.size() == 0) begin
                $display("%0t: unexpected chunk, actual %h kind %0d", $time,
                         m_tdata[63:0], m_tuser);
                errors++;
            end else begin
                e = expected_chunks.pop_front();
                check_field("kind", 64'(e.kind), 64'(m_tuser));
                check_field("chunk_bytes", e.data, m_tdata[63:0]);
                check_field("byte_count", 64'(e.cnt), 64'(m_tdata[67:64]));
                check_field("last", 64'(e.last), 64'(m_tlast));
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("property_line_tokenizer_core verification failed");
            $finish;
        end
    end

    initial begin
        drow_t dirs[28];
        int    first;
        int    nres;
        chunk_t got;
        dirs = '{
            '{8'h41, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_EQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h31, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_SEMI, 1'b1, KIND_NAME, 64'h61, 4'd1, 1'b0},
            '{CH_EQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h58, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_LF, 1'b1, KIND_RAW, 64'h783D, 4'd2, 1'b1},
            '{8'h00, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'hFF, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_LF, 1'b1, KIND_RAW, 64'hFF00, 4'd2, 1'b1},
            '{8'h62, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_EQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_DQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h71, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_DQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_CR, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_LF, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_SLASH, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_STAR, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h7A, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_STAR, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_SLASH, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h63, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_EQ, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_BSL, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_LF, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{8'h39, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0},
            '{CH_SEMI, 1'b0, 2'd0, 64'h0, 4'd0, 1'b0}
        };
        held_lo = '0;
        held_hi = '0;
        held_n = 0;
        raw_n = 0;
        tok_len = 0;
        eq_pos = 0;
        eq_seen = 1'b0;
        qpar = '0;
        fold_on = 1'b0;

        // Hold reset, then release it at a rising edge.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table with case folding on.
        write_fold(1'b1);
        foreach (dirs[i]) begin
            send_byte(dirs[i].b, first, nres);
            if (dirs[i].chk) begin
                got = expected_chunks[first];
                if (nres == 0 || got.kind !== dirs[i].kind || got.data !== dirs[i].data ||
                    got.cnt !== dirs[i].cnt || got.last !== dirs[i].last) begin
                    $display("%0t: table row %0d, expected %h/%0d, predicted %h/%0d",
                             $time, i, dirs[i].data, dirs[i].cnt, got.data, got.cnt);
                    errors++;
                end
            end
        end
        s_tvalid <= 1'b0;
        drain();

        // Random phases across both fold settings.
        write_fold(1'b0);
        run_random(PHASE_ITEMS, 1'b0);
        write_fold(1'b1);
        hold_req++;
        run_random(PHASE_ITEMS, 1'b0);
        write_fold(1'b0);
        steady = 1'b1;
        run_random(PHASE_ITEMS / 2, 1'b0);
        steady = 1'b0;
        write_fold(1'b1);
        run_random(PHASE_ITEMS, 1'b1);

        if (expected_chunks.size() != 0) begin
            $display("%0t: %0d expected chunks never arrived", $time, expected_chunks.size());
            errors++;
        end
        $display("Sent %0d bytes with both fold settings, %0d forced long tokens.",
                 items_sent, long_tokens);
        $display("Checked %0d result chunks, %0d errors.", chunks_seen, errors);
        if (errors == 0) begin
            $display("property_line_tokenizer_core verification clean");
        end else begin
            $display("property_line_tokenizer_core verification failed");
        end
        $finish;
    end

endmodule
